@@ hw/rtl/pfa_pkg.sv @@
//------------------------------------------------------------------------------
// Partition fit allocator package
// Field widths, configuration register indexes and the policy and kind codes
// that the channels and the allocator share.
//------------------------------------------------------------------------------
`default_nettype none

package pfa_pkg;

    localparam int KIND_W    = 1;
    localparam int ENTRY_W   = 4;
    localparam int SIZE_W    = 16;
    localparam int POLICY_W  = 2;
    localparam int BCOUNT_W  = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'd1;

    // Input item kinds.
    localparam logic [KIND_W-1:0] KIND_LOAD    = 1'b0;
    localparam logic [KIND_W-1:0] KIND_REQUEST = 1'b1;

    typedef enum logic [POLICY_W-1:0] {
        POL_FIRST = 2'd0,
        POL_BEST  = 2'd1,
        POL_WORST = 2'd2,
        POL_NEXT  = 2'd3
    } policy_t;

    localparam logic [POLICY_W-1:0] POLICY_RESET      = 2'd0;
    localparam logic [BCOUNT_W-1:0] BLOCK_COUNT_RESET = 5'd16;

endpackage

`default_nettype wire

@@ hw/rtl/pfa_if.sv @@
//------------------------------------------------------------------------------
// Partition fit allocator channels
// Valid/ready channels for input items (loads and requests) and for results.
//------------------------------------------------------------------------------
`default_nettype none

interface pfa_req_if;
    logic                         valid;
    logic                         ready;
    logic [pfa_pkg::KIND_W-1:0]   kind;
    logic [pfa_pkg::ENTRY_W-1:0]  entry_index;
    logic [pfa_pkg::SIZE_W-1:0]   size;

    modport source (output valid, output kind, output entry_index, output size,
                    input ready);
    modport sink   (input valid, input kind, input entry_index, input size,
                    output ready);
endinterface

interface pfa_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         granted;
    logic [pfa_pkg::ENTRY_W-1:0]  block_index;
    logic [pfa_pkg::SIZE_W-1:0]   size_before;

    modport source (output valid, output granted, output block_index,
                    output size_before, input ready);
    modport sink   (input valid, input granted, input block_index,
                    input size_before, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/partition_fit_allocator_top.sv @@
// Load item: stored in capacity memory on transfer if its index is below MAX_BLOCKS.
// Request: with N = block_count capped at MAX_BLOCKS, the scan state issues one memory
// read for each of N entries, the drain state takes the last read and the finish state
// registers the result and writes back the chosen entry; a block_count of zero goes
// from idle to the finish and refuses. Only idle takes items; a waiting result stalls
// the finish. Reset clears control, policy (first fit), block_count (16) and pointer.
//------------------------------------------------------------------------------
// Partition fit allocator
// Picks a partition under first, best, worst or next fit from a capacity
// memory scanned one entry per cycle, then subtracts the request from it.
//------------------------------------------------------------------------------
`default_nettype none

module partition_fit_allocator_top #(
    parameter int MAX_BLOCKS = 16,
    parameter int SIZE_WIDTH = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [pfa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [pfa_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    pfa_req_if.sink                               req,
    pfa_rsp_if.source                             rsp
);

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    pfa_pkg::policy_t                  policy_reg;
    logic [pfa_pkg::BCOUNT_W-1:0]      block_count_reg;
    logic [IDX_W-1:0]                  ptr_reg;

    logic [SIZE_WIDTH-1:0]             cap_mem [MAX_BLOCKS];
    logic [SIZE_WIDTH-1:0]             rd_data_reg;
    logic                              rd_pend_reg;

    logic [SIZE_WIDTH-1:0]             want_reg;
    logic [CNT_W-1:0]                  count_reg;
    logic [CNT_W-1:0]                  left_reg;
    logic [IDX_W-1:0]                  scan_idx_reg;
    logic [IDX_W-1:0]                  rd_tag_reg;
    logic                              found_reg;
    logic [IDX_W-1:0]                  chosen_idx_reg;
    logic [SIZE_WIDTH-1:0]             chosen_cap_reg;

    logic                              out_valid_reg;
    logic                              out_granted_reg;
    logic [pfa_pkg::ENTRY_W-1:0]       out_index_reg;
    logic [pfa_pkg::SIZE_W-1:0]        out_size_reg;

    logic [CNT_W-1:0]                  active_count;
    logic [IDX_W-1:0]                  start_idx;
    logic [IDX_W-1:0]                  scan_idx_inc;
    logic                              req_xfer;
    logic                              load_ok;
    logic                              out_free;
    logic                              fits;
    logic                              take;
    logic                              mem_we;
    logic [IDX_W-1:0]                  mem_waddr;
    logic [SIZE_WIDTH-1:0]             mem_wdata;

    assign req.ready     = (state_reg == ST_IDLE);
    assign req_xfer      = req.valid && req.ready;
    assign out_free      = !out_valid_reg || rsp.ready;

    assign rsp.valid       = out_valid_reg;
    assign rsp.granted     = out_granted_reg;
    assign rsp.block_index = out_index_reg;
    assign rsp.size_before = out_size_reg;

    // Counts above the table size saturate.
    always_comb
    begin
        if (32'(block_count_reg) > 32'(MAX_BLOCKS))
        begin
            active_count = CNT_W'(MAX_BLOCKS);
        end
        else
        begin
            active_count = CNT_W'(block_count_reg);
        end
    end

    // A stale next-fit pointer restarts the scan at entry zero.
    always_comb
    begin
        if (policy_reg == pfa_pkg::POL_NEXT && CNT_W'(ptr_reg) < active_count)
        begin
            start_idx = ptr_reg;
        end
        else
        begin
            start_idx = '0;
        end
    end

    always_comb
    begin
        if (CNT_W'(scan_idx_reg) + CNT_W'(1) == count_reg)
        begin
            scan_idx_inc = '0;
        end
        else
        begin
            scan_idx_inc = scan_idx_reg + IDX_W'(1);
        end
    end

    assign load_ok = 32'(req.entry_index) < 32'(MAX_BLOCKS);

    // Best and worst fit compare capacities: with a fixed request the
    // leftover orders the same way. Strict compares keep the lowest index.
    assign fits = rd_data_reg >= want_reg;
    always_comb
    begin
        take = 1'b0;
        if (rd_pend_reg && fits)
        begin
            if (!found_reg)
            begin
                take = 1'b1;
            end
            else if (policy_reg == pfa_pkg::POL_BEST)
            begin
                take = rd_data_reg < chosen_cap_reg;
            end
            else if (policy_reg == pfa_pkg::POL_WORST)
            begin
                take = rd_data_reg > chosen_cap_reg;
            end
        end
    end

    // The single write port serves loads in idle and grants at the finish.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = chosen_idx_reg;
        mem_wdata = chosen_cap_reg - want_reg;
        if (state_reg == ST_IDLE)
        begin
            mem_we    = req_xfer && req.kind == pfa_pkg::KIND_LOAD && load_ok;
            mem_waddr = IDX_W'(req.entry_index);
            mem_wdata = SIZE_WIDTH'(req.size);
        end
        else if (state_reg == ST_FINISH)
        begin
            mem_we = out_free && found_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cap_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= cap_mem[scan_idx_reg];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer && req.kind == pfa_pkg::KIND_REQUEST)
                begin
                    state_next = (active_count == '0) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (left_reg == CNT_W'(1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            policy_reg      <= pfa_pkg::policy_t'(pfa_pkg::POLICY_RESET);
            block_count_reg <= pfa_pkg::BLOCK_COUNT_RESET;
            ptr_reg         <= '0;
            rd_pend_reg     <= 1'b0;
            found_reg       <= 1'b0;
            left_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= (state_reg == ST_SCAN);

            if (cfg_we)
            begin
                unique case (cfg_index)
                    pfa_pkg::CFG_POLICY:
                    begin
                        policy_reg <= pfa_pkg::policy_t'(cfg_wdata[pfa_pkg::POLICY_W-1:0]);
                    end
                    pfa_pkg::CFG_BLOCK_COUNT:
                    begin
                        block_count_reg <= cfg_wdata[pfa_pkg::BCOUNT_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (state_reg == ST_IDLE && req_xfer)
            begin
                found_reg <= 1'b0;
                left_reg  <= active_count;
            end
            else if (state_reg == ST_SCAN)
            begin
                left_reg <= left_reg - CNT_W'(1);
            end

            if (take)
            begin
                found_reg <= 1'b1;
            end

            if (state_reg == ST_FINISH && out_free)
            begin
                out_valid_reg <= 1'b1;
                if (found_reg && policy_reg == pfa_pkg::POL_NEXT)
                begin
                    ptr_reg <= chosen_idx_reg;
                end
            end
            else if (rsp.valid && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && req_xfer)
        begin
            want_reg     <= SIZE_WIDTH'(req.size);
            count_reg    <= active_count;
            scan_idx_reg <= start_idx;
        end
        else if (state_reg == ST_SCAN)
        begin
            scan_idx_reg <= scan_idx_inc;
        end

        rd_tag_reg <= scan_idx_reg;

        if (take)
        begin
            chosen_idx_reg <= rd_tag_reg;
            chosen_cap_reg <= rd_data_reg;
        end

        if (state_reg == ST_FINISH && out_free)
        begin
            out_granted_reg <= found_reg;
            out_index_reg   <= found_reg ? pfa_pkg::ENTRY_W'(chosen_idx_reg) : '0;
            out_size_reg    <= found_reg ? pfa_pkg::SIZE_W'(chosen_cap_reg) : '0;
        end
    end

endmodule

`default_nettype wire
